### design/wbps_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the wildcard byte pattern scanner.
// No dependencies; used by every other design file.
package wbps_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int WIN_DEPTH   = MAX_PATTERN - 1;
    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = 32;
    localparam int LEN_W       = $clog2(MAX_PATTERN) + 1;
    localparam int FILL_W      = $clog2(WIN_DEPTH + 1);
    localparam int CARE_W      = 16;
    localparam int PDATA_W     = 64;
    localparam int PADDR_W     = 5;
    localparam int REG_IDX_W   = 2;

    // register indexes (byte address = 8 * index)
    typedef logic [REG_IDX_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_PATTERN_LOW  = 2'd0;
    localparam t_reg_idx REG_PATTERN_HIGH = 2'd1;
    localparam t_reg_idx REG_CARE_MASK    = 2'd2;
    localparam t_reg_idx REG_PATTERN_LEN  = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [ADDR_W-1:0] scan_address;
        logic              region_start;
        logic              last_byte;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } t_result;

    // signature pre-aligned to window positions: entry k compares against
    // the byte k steps older than the current one
    typedef struct packed {
        logic [LEN_W-1:0]                   len;
        logic [MAX_PATTERN-1:0][BYTE_W-1:0] sig_al;
        logic [MAX_PATTERN-1:0]             care_al;
    } t_cfg;

    // zero reads as one, anything above the maximum saturates
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
        logic [LEN_W-1:0] n;
        n = raw;
        if (raw == '0) begin
            n = LEN_W'(1);
        end else if (raw > LEN_W'(MAX_PATTERN)) begin
            n = LEN_W'(MAX_PATTERN);
        end
        return n;
    endfunction

endpackage

### design/wbps_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for scanner input bytes and scan results.
// Depends on wbps_pkg for field widths.
interface wbps_in_if;
    logic                        valid;
    logic                        ready;
    logic [wbps_pkg::BYTE_W-1:0] data_byte;
    logic [wbps_pkg::ADDR_W-1:0] scan_address;
    logic                        region_start;
    logic                        last_byte;

    modport source (output valid, data_byte, scan_address, region_start, last_byte,
                    input ready);
    modport sink   (input valid, data_byte, scan_address, region_start, last_byte,
                    output ready);
endinterface

interface wbps_out_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [wbps_pkg::ADDR_W-1:0] match_address;

    modport source (output valid, found, match_address, input ready);
    modport sink   (input valid, found, match_address, output ready);
endinterface

### design/wbps_cfg_regs.sv
`timescale 1ns / 1ps
// APB configuration registers and signature alignment for the scanner.
// Depends on wbps_pkg.
module wbps_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wbps_pkg::PADDR_W-1:0]   paddr,
    input  logic [wbps_pkg::PDATA_W-1:0]   pwdata,
    output logic [wbps_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    output wbps_pkg::t_cfg                 o_cfg
);
    import wbps_pkg::*;

    logic [PDATA_W-1:0] r_pattern_low;
    logic [PDATA_W-1:0] r_pattern_high;
    logic [CARE_W-1:0]  r_care_mask;
    logic [LEN_W-1:0]   r_pattern_len;

    t_reg_idx                           reg_idx;
    logic                               wr_en;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] sig;
    logic [LEN_W-1:0]                   len;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1 -: REG_IDX_W];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low  <= '0;
            r_pattern_high <= '0;
            r_care_mask    <= '1;
            r_pattern_len  <= LEN_W'(1);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_PATTERN_LOW:  r_pattern_low  <= pwdata;
                REG_PATTERN_HIGH: r_pattern_high <= pwdata;
                REG_CARE_MASK:    r_care_mask    <= pwdata[CARE_W-1:0];
                REG_PATTERN_LEN:  r_pattern_len  <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_PATTERN_LOW:  prdata = r_pattern_low;
            REG_PATTERN_HIGH: prdata = r_pattern_high;
            REG_CARE_MASK:    prdata = PDATA_W'(r_care_mask);
            REG_PATTERN_LEN:  prdata = PDATA_W'(r_pattern_len);
            default:          prdata = '0;
        endcase
    end

    assign sig = {r_pattern_high, r_pattern_low};
    assign len = eff_len(r_pattern_len);

    // window position k holds signature byte len-1-k; positions past the
    // length never compare
    always_comb begin
        logic [LEN_W-1:0] d;
        o_cfg.len = len;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            d = len - LEN_W'(1) - LEN_W'(k);
            if (LEN_W'(k) < len) begin
                o_cfg.sig_al[k]  = sig[d[LEN_W-2:0]];
                o_cfg.care_al[k] = r_care_mask[d[LEN_W-2:0]];
            end else begin
                o_cfg.sig_al[k]  = '0;
                o_cfg.care_al[k] = 1'b0;
            end
        end
    end

endmodule

### design/wbps_match_core.sv
`timescale 1ns / 1ps
// Input register, byte window, masked compare and first-hit tracking.
// Depends on wbps_pkg.
module wbps_match_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wbps_pkg::t_cfg     i_cfg,
    input  logic               i_in_valid,
    input  wbps_pkg::t_in_item i_in_item,
    output logic               o_in_ready,
    input  logic               i_res_ready,
    output logic               o_res_valid,
    output wbps_pkg::t_result  o_res
);
    import wbps_pkg::*;

    logic                             r_in_valid;
    t_in_item                         r_in;
    logic [WIN_DEPTH-1:0][BYTE_W-1:0] r_win;
    logic [FILL_W-1:0]                r_fill;
    logic                             r_hit;
    logic [ADDR_W-1:0]                r_addr;

    logic [FILL_W-1:0]                  n_fill;
    logic                               n_hit;
    logic [ADDR_W-1:0]                  n_addr;
    logic                               adv;
    logic [FILL_W-1:0]                  fill0;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] hist;
    logic [MAX_PATTERN-1:0]             byte_ok;
    logic                               cand;

    // a non-last byte never waits on the output side
    assign adv         = r_in_valid && (!r_in.last_byte || i_res_ready);
    assign o_in_ready  = !r_in_valid || adv;
    assign o_res_valid = adv && r_in.last_byte;

    assign fill0 = r_in.region_start ? '0 : r_fill;
    assign hist  = {r_win, r_in.data_byte};

    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            byte_ok[k] = !i_cfg.care_al[k] || (hist[k] == i_cfg.sig_al[k]);
        end
    end

    assign cand   = !r_hit && ((LEN_W'(fill0) + LEN_W'(1)) >= i_cfg.len) && (&byte_ok);
    assign n_hit  = r_hit || cand;
    assign n_addr = cand ? (r_in.scan_address - ADDR_W'(i_cfg.len - LEN_W'(1))) : r_addr;
    assign n_fill = r_in.last_byte ? '0 :
                    (fill0 == FILL_W'(WIN_DEPTH)) ? fill0 : fill0 + FILL_W'(1);

    assign o_res.found         = n_hit;
    assign o_res.match_address = n_hit ? n_addr : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_fill     <= '0;
            r_hit      <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_fill <= n_fill;
                r_hit  <= n_hit && !r_in.last_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (adv) begin
            r_win  <= hist[WIN_DEPTH-1:0];
            r_addr <= n_addr;
        end
    end

endmodule

### design/wbps_out_reg.sv
`timescale 1ns / 1ps
// Result output register; holds a result until the sink takes it.
// Depends on wbps_pkg.
module wbps_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  wbps_pkg::t_result i_res,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_ready,
    output wbps_pkg::t_result o_res
);
    import wbps_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

### design/wildcard_byte_pattern_scanner_unit.sv
`timescale 1ns / 1ps
// Wildcard byte pattern scanner: top level. Uses wbps_pkg, wbps_if, wbps_cfg_regs,
// wbps_match_core and wbps_out_reg.
// Throughput: one byte per cycle unless a last byte finds the output register full.
// Last-byte result path: input register, compare, output register, o_out.
// Reset (i_rst_n, synchronous, low): empties the pipeline and scan state; registers
// return to pattern 0, care mask all ones, length 1.
module wildcard_byte_pattern_scanner_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    wbps_in_if.sink                       i_in,
    wbps_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wbps_pkg::PADDR_W-1:0]  paddr,
    input  logic [wbps_pkg::PDATA_W-1:0]  pwdata,
    output logic [wbps_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import wbps_pkg::*;

    t_cfg     cfg;
    t_in_item in_item;
    t_result  core_res;
    t_result  out_res;
    logic     core_res_valid;
    logic     out_can_load;
    logic     core_in_ready;

    // The user must keep registers static while bytes flow; the block does not
    // enforce it. The aligned signature (byte per slot) comes straight off them.
    wbps_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign in_item.data_byte    = i_in.data_byte;
    assign in_item.scan_address = i_in.scan_address;
    assign in_item.region_start = i_in.region_start;
    assign in_item.last_byte    = i_in.last_byte;
    assign i_in.ready           = core_in_ready;

    // Stage 1 registers the byte; stage 2 compares it with the window,
    // updates the first-hit state and on the last byte hands a result
    // to the output register. Only a last byte can stall the pipe.
    wbps_match_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in.valid),
        .i_in_item   (in_item),
        .o_in_ready  (core_in_ready),
        .i_res_ready (out_can_load),
        .o_res_valid (core_res_valid),
        .o_res       (core_res)
    );

    wbps_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (core_res_valid),
        .i_res      (core_res),
        .o_can_load (out_can_load),
        .o_valid    (o_out.valid),
        .i_ready    (o_out.ready),
        .o_res      (out_res)
    );

    assign o_out.found         = out_res.found;
    assign o_out.match_address = out_res.match_address;

    // no address reported without a match
    a_no_addr_without_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |-> (o_out.match_address == '0))
        else $error("match address nonzero with found clear");

    // input backpressure only comes from a stalled, full output register
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (o_out.valid && !o_out.ready))
        else $error("input stalled without output backpressure");

    // output register is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for wildcard_byte_pattern_scanner_unit: streams scans of addressed
// bytes, predicts each end-of-scan result and checks every result transfer field by field.
// Depends on wbps_pkg and wbps_if from the design folder.
module tb_top;
    import wbps_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 155;
    localparam int NUM_PHASES     = 8;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    wbps_in_if  in_if ();
    wbps_out_if out_if ();

    wildcard_byte_pattern_scanner_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    // register shadow, updated as each write lands
    logic [63:0] cfg_pat_lo;
    logic [63:0] cfg_pat_hi;
    logic [15:0] cfg_care;
    logic [4:0]  cfg_len_raw;

    // scan state of the predictor
    logic [7:0]  scan_win [MAX_PATTERN-1];
    int          scan_fill;
    bit          scan_hit;
    logic [31:0] scan_hit_addr;

    t_in_item pending_bytes [$];
    t_result  expected_results [$];

    int src_idle_pct;
    int snk_stall_pct;
    int bytes_queued;
    int bytes_accepted;
    int scans_queued;
    int settings_used;
    int results_checked;
    int hits_checked;
    int err_count;
    int quiet_cycles;

    t_in_item drv_item;
    t_in_item seen_item;
    t_result  pred_result;
    t_result  want;
    bit       pred_emits;
    bit       moved;

    function automatic int active_len();
        int n;
        n = cfg_len_raw;
        if (n == 0) n = 1;
        if (n > MAX_PATTERN) n = MAX_PATTERN;
        return n;
    endfunction

    function automatic logic [7:0] sig_byte(int k);
        logic [127:0] s;
        s = {cfg_pat_hi, cfg_pat_lo};
        return s[8*k +: 8];
    endfunction

    task automatic clear_scan_state();
        foreach (scan_win[k]) scan_win[k] = 8'h00;
        scan_fill     = 0;
        scan_hit      = 1'b0;
        scan_hit_addr = '0;
    endtask

    // one byte through the scanner: window compare, shift, result on the last byte
    task automatic predict_scan_byte(input t_in_item it, output bit emits, output t_result res);
        int n;
        int k;
        bit ok;
        logic [7:0] b;
        n = active_len();
        if (it.region_start) begin
            foreach (scan_win[j]) scan_win[j] = 8'h00;
            scan_fill = 0;
        end
        if (!scan_hit && scan_fill + 1 >= n) begin
            ok = 1'b1;
            for (k = 0; k < n; k++) begin
                if (cfg_care[k]) begin
                    if (k == n - 1) b = it.data_byte;
                    else b = scan_win[n - 2 - k];
                    if (b != sig_byte(k)) ok = 1'b0;
                end
            end
            if (ok) begin
                scan_hit      = 1'b1;
                scan_hit_addr = it.scan_address - 32'(n - 1);
            end
        end
        for (k = MAX_PATTERN - 2; k > 0; k--) scan_win[k] = scan_win[k-1];
        scan_win[0] = it.data_byte;
        if (scan_fill < MAX_PATTERN - 1) scan_fill++;
        emits             = it.last_byte;
        res.found         = scan_hit;
        res.match_address = scan_hit ? scan_hit_addr : '0;
        if (it.last_byte) clear_scan_state();
    endtask

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 30) $display("MISMATCH: %s", msg);
    endtask

    // setup cycle, then access cycle; the register takes the data at the edge after it
    task automatic write_reg(input t_reg_idx idx, input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PATTERN_LOW:  cfg_pat_lo  = value;
            REG_PATTERN_HIGH: cfg_pat_hi  = value;
            REG_CARE_MASK:    cfg_care    = value[15:0];
            REG_PATTERN_LEN:  cfg_len_raw = value[4:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [15:0] care, input logic [4:0] len);
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_CARE_MASK, 64'(care));
        write_reg(REG_PATTERN_LEN, 64'(len));
        settings_used++;
    endtask

    task automatic queue_byte(input logic [7:0] d, input logic [31:0] a, input bit rs,
                              input bit lb);
        t_in_item it;
        it.data_byte    = d;
        it.scan_address = a;
        it.region_start = rs;
        it.last_byte    = lb;
        pending_bytes.push_back(it);
        bytes_queued++;
    endtask

    // a scan of one to three regions; some carry a planted (sometimes spoiled) signature
    // over a background salted with signature bytes, some are pure noise
    task automatic queue_scan();
        int n;
        int nreg;
        int rlen;
        int pos;
        int flip;
        int r;
        int b;
        int k;
        bit noise;
        bit rs;
        bit lb;
        logic [31:0] base;
        logic [31:0] a;
        logic [7:0] rb [$];
        n     = active_len();
        noise = ($urandom_range(99) < 15);
        nreg  = ($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1;
        for (r = 0; r < nreg; r++) begin
            rlen = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, n + 6);
            rb.delete();
            for (b = 0; b < rlen; b++) begin
                rb.push_back($urandom_range(1) ? 8'($urandom) : sig_byte($urandom_range(0, n - 1)));
            end
            if (!noise && rlen >= n && $urandom_range(99) < 60) begin
                pos = $urandom_range(0, rlen - n);
                for (k = 0; k < n; k++) begin
                    rb[pos + k] = cfg_care[k] ? sig_byte(k) : 8'($urandom);
                end
                if ($urandom_range(3) == 0) begin
                    flip = $urandom_range(0, n - 1);
                    if (cfg_care[flip]) begin
                        rb[pos + flip] = sig_byte(flip) ^ 8'($urandom_range(1, 255));
                    end
                end
            end
            case ($urandom_range(3))
                0: base = 32'hFFFF_FFFF - 32'($urandom_range(0, 24));
                1: base = 32'($urandom_range(0, 24));
                default: base = $urandom;
            endcase
            for (b = 0; b < rlen; b++) begin
                rs = noise ? ($urandom_range(7) == 0) : (b == 0);
                lb = (r == nreg - 1) && (b == rlen - 1);
                a  = (noise && $urandom_range(9) == 0) ? $urandom : base + 32'(b);
                queue_byte(rb[b], a, rs, lb);
            end
        end
        scans_queued++;
    endtask

    // wait for every byte and every result, then let the pipeline empty
    task automatic drain();
        while (bytes_accepted != bytes_queued || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // input driver: hold a byte until it transfers, then offer the next or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                drv_item = pending_bytes.pop_front();
                in_if.valid        <= 1'b1;
                in_if.data_byte    <= drv_item.data_byte;
                in_if.scan_address <= drv_item.scan_address;
                in_if.region_start <= drv_item.region_start;
                in_if.last_byte    <= drv_item.last_byte;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // monitor: predict on every input transfer, check every result transfer;
    // the watchdog counts cycles with neither
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (in_if.valid && in_if.ready) begin
                seen_item.data_byte    = in_if.data_byte;
                seen_item.scan_address = in_if.scan_address;
                seen_item.region_start = in_if.region_start;
                seen_item.last_byte    = in_if.last_byte;
                predict_scan_byte(seen_item, pred_emits, pred_result);
                if (pred_emits) expected_results.push_back(pred_result);
                bytes_accepted++;
                moved = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                moved = 1'b1;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with none pending: found=%0b addr=%08h",
                                              out_if.found, out_if.match_address));
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (want.found) hits_checked++;
                    if (out_if.found !== want.found) begin
                        report_mismatch($sformatf("result %0d found: got %0b want %0b",
                                                  results_checked, out_if.found, want.found));
                    end
                    if (out_if.match_address !== want.match_address) begin
                        report_mismatch($sformatf("result %0d match_address: got %08h want %08h",
                                                  results_checked, out_if.match_address,
                                                  want.match_address));
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        int p;
        int phase_start;
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_if.valid        = 1'b0;
        in_if.data_byte    = '0;
        in_if.scan_address = '0;
        in_if.region_start = 1'b0;
        in_if.last_byte    = 1'b0;
        out_if.ready       = 1'b1;
        src_idle_pct       = 0;
        snk_stall_pct      = 0;
        bytes_queued       = 0;
        bytes_accepted     = 0;
        scans_queued       = 0;
        settings_used      = 1;
        results_checked    = 0;
        hits_checked       = 0;
        err_count          = 0;
        quiet_cycles       = 0;
        cfg_pat_lo         = '0;
        cfg_pat_hi         = '0;
        cfg_care           = 16'hFFFF;
        cfg_len_raw        = 5'd1;
        clear_scan_state();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: one-byte signature 00 hits on the very first byte
        queue_byte(8'h00, 32'h0000_0000, 1'b1, 1'b0);
        queue_byte(8'hFF, 32'h0000_0001, 1'b0, 1'b0);
        queue_byte(8'h7F, 32'h0000_0002, 1'b0, 1'b1);
        scans_queued++;
        drain();

        // AA ?? CC, mask bits above the length (all but bit 3) set but unused
        set_config(64'h0000_0000_00CC_BBAA, 64'h0, 16'hFFF5, 5'd3);
        // wildcard in the middle; a later second match is ignored
        queue_byte(8'hAA, 32'h0000_1000, 1'b1, 1'b0);
        queue_byte(8'h11, 32'h0000_1001, 1'b0, 1'b0);
        queue_byte(8'hCC, 32'h0000_1002, 1'b0, 1'b0);
        queue_byte(8'h5A, 32'h0000_1003, 1'b0, 1'b0);
        queue_byte(8'hAA, 32'h0000_1004, 1'b0, 1'b0);
        queue_byte(8'h22, 32'h0000_1005, 1'b0, 1'b0);
        queue_byte(8'hCC, 32'h0000_1006, 1'b0, 1'b1);
        // region start in the middle of a candidate kills it
        queue_byte(8'hAA, 32'h0000_2000, 1'b1, 1'b0);
        queue_byte(8'h11, 32'h0000_2001, 1'b0, 1'b0);
        queue_byte(8'hCC, 32'h0000_2002, 1'b1, 1'b1);
        // one byte that opens a region and ends the scan
        queue_byte(8'hCC, 32'h0000_3000, 1'b1, 1'b1);
        // match straddling the top of the address space
        queue_byte(8'hAA, 32'hFFFF_FFFE, 1'b1, 1'b0);
        queue_byte(8'h33, 32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_byte(8'hCC, 32'h0000_0000, 1'b0, 1'b1);
        // non-contiguous addresses: start address wraps below zero
        queue_byte(8'hAA, 32'h0000_0005, 1'b1, 1'b0);
        queue_byte(8'h00, 32'h0000_0006, 1'b0, 1'b0);
        queue_byte(8'hCC, 32'h0000_0000, 1'b0, 1'b1);
        scans_queued += 5;
        drain();

        // length zero acts as one
        set_config(64'h0000_0000_0000_00AA, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 5'd0);
        queue_byte(8'hAA, 32'hFFFF_FFFF, 1'b1, 1'b1);
        scans_queued++;
        drain();

        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: set_config({$urandom, $urandom}, {$urandom, $urandom}, 16'hFFFF, 5'd16);
                1: set_config({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom), 5'd1);
                2: set_config({$urandom, $urandom}, {$urandom, $urandom}, 16'hFFFF, 5'd0);
                3: set_config({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom), 5'd31);
                4: set_config({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom),
                              5'($urandom_range(2, 15)));
                5: set_config({$urandom, $urandom}, {$urandom, $urandom}, 16'h0000, 5'd8);
                6: set_config(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 5'd16);
                default: set_config(64'h0, 64'h0, 16'($urandom), 5'd17);
            endcase
            // pacing: free-running, sparse sender, stalling receiver, both
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 63; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 63; end
                default: begin src_idle_pct = 35; snk_stall_pct = 35; end
            endcase
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < PHASE_BYTES) queue_scan();
            drain();
        end

        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end
        $display("Covered %0d bytes in %0d scans under %0d register settings and 4 pacing modes.",
                 bytes_accepted, scans_queued, settings_used);
        $display("Checked %0d results (%0d with a match); %0d mismatches.",
                 results_checked, hits_checked, err_count);
        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
